// ----- rtl/core/mstw_pkg.sv -----
// Shared types and constants for the minimum spanning tree weight block.
package mstw_pkg;

  localparam int VertexPortW = 11;
  localparam int WeightW     = 16;
  localparam int SumW        = 32;
  localparam int TakenW      = 10;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_INIT,
    S_CHECK,
    S_SCAN,
    S_ISSUE,
    S_UNION,
    S_DONE
  } mst_state_e;

  typedef enum logic [2:0] {
    U_IDLE,
    U_INIT,
    U_RD,
    U_CK,
    U_JOIN
  } uf_state_e;

  typedef struct packed {
    logic init;
    logic go;
  } uf_ctrl_t;

  typedef struct packed {
    logic done;
    logic merged;
  } uf_rsp_t;

endpackage

// ----- rtl/core/mstw_uf.sv -----
// Union-find unit: parent table, init sweep, root walk and merge.
module mstw_uf #(
  parameter int MAX_VERTICES = 1024,
  parameter int VW           = 10,
  parameter int NW           = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mstw_pkg::uf_ctrl_t ctrl_i,
  input  logic [NW-1:0]     n_i,
  input  logic [VW-1:0]     a_i,
  input  logic [VW-1:0]     b_i,
  output mstw_pkg::uf_rsp_t  rsp_o
);
  import mstw_pkg::*;

  logic [VW-1:0] parent_mem [MAX_VERTICES];

  uf_state_e     state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] x_q, x_d;
  logic [VW-1:0] ra_q, ra_d;
  logic          phase_q, phase_d;
  logic [VW-1:0] rdata_q;

  logic          we;
  logic [VW-1:0] waddr;
  logic [VW-1:0] wdata;
  logic          re;
  logic          init_end;

  assign init_end = (cnt_q == n_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE: begin
        if (ctrl_i.init) begin
          state_d = U_INIT;
        end else if (ctrl_i.go) begin
          state_d = U_RD;
        end
      end
      U_INIT: begin
        if (init_end) begin
          state_d = U_IDLE;
        end
      end
      U_RD:   state_d = U_CK;
      U_CK: begin
        if (rdata_q != x_q) begin
          state_d = U_RD;
        end else if (phase_q) begin
          state_d = U_JOIN;
        end else begin
          state_d = U_RD;
        end
      end
      U_JOIN:  state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_comb begin
    rsp_o = '0;
    we    = 1'b0;
    waddr = x_q;
    wdata = ra_q;
    re    = 1'b0;
    unique case (state_q)
      U_INIT: begin
        rsp_o.done = init_end;
        we         = !init_end;
        waddr      = cnt_q[VW-1:0];
        wdata      = cnt_q[VW-1:0];
      end
      U_RD: re = 1'b1;
      U_JOIN: begin
        rsp_o.done   = 1'b1;
        rsp_o.merged = (ra_q != x_q);
        we           = (ra_q != x_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    x_d     = x_q;
    ra_d    = ra_q;
    phase_d = phase_q;
    unique case (state_q)
      U_IDLE: begin
        cnt_d   = '0;
        x_d     = a_i;
        phase_d = 1'b0;
      end
      U_INIT: cnt_d = cnt_q + NW'(1);
      U_CK: begin
        if (rdata_q != x_q) begin
          x_d = rdata_q;
        end else if (!phase_q) begin
          // root of the first end found, walk the second
          ra_d    = x_q;
          x_d     = b_i;
          phase_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    ra_q <= ra_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      parent_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= parent_mem[x_q];
    end
  end

endmodule

// ----- rtl/core/minimum_spanning_tree_weight.sv -----
// Top level: edge store, min-key scan sequencer and tree weight accumulation.
//
//   port group   dir  handshake                  fields
//   cfg          in   cfg_we_i                   cfg_wdata_i (vertex_count)
//   in           in   in_valid_i / in_stall_o    end_a_i end_b_i weight_i last_edge_i
//   out          out  out_valid_o / out_stall_i  tree_weight_o edges_taken_o
//
// Edges load one per cycle while in_stall_o is low. After the last edge the parent
// table is set up, then for every edge visited in weight order come a check state,
// one scan of the store, the root walks (a read and a check state per parent read)
// and the issue and merge states. The single scan comparator sets the pace: the
// scan repeats once per visited edge.
// Reset clears control state; the edge store holds no reset value.
// in_stall_o stays high from the last edge until the result is registered.
module minimum_spanning_tree_weight #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mstw_pkg::VertexPortW-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mstw_pkg::VertexPortW-1:0]  end_a_i,
  input  logic [mstw_pkg::VertexPortW-1:0]  end_b_i,
  input  logic signed [mstw_pkg::WeightW-1:0] weight_i,
  input  logic                              last_edge_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mstw_pkg::SumW-1:0]  tree_weight_o,
  output logic [mstw_pkg::TakenW-1:0]       edges_taken_o
);
  import mstw_pkg::*;

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int NW   = $clog2(MAX_VERTICES + 1);
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int KW   = WeightW + EAW;
  localparam int MW   = 2 * VW + WeightW;

  logic [MW-1:0] edge_mem [MAX_EDGES];

  mst_state_e          state_q, state_d;
  logic [VertexPortW-1:0] vertex_count_q;
  logic [ECW-1:0]      edge_total_q;
  logic [NW-1:0]       n_q;
  logic [NW-1:0]       taken_q;
  logic [SumW-1:0]     total_q;
  logic [ECW-1:0]      scan_addr_q;
  logic                rv_q;
  logic [EAW-1:0]      ridx_q;
  logic [MW-1:0]       rdata_q;
  logic                have_best_q;
  logic [KW-1:0]       best_key_q;
  logic [VW-1:0]       best_u_q, best_v_q;
  logic [WeightW-1:0]  best_w_q;
  logic                have_prev_q;
  logic [KW-1:0]       prev_key_q;
  logic                out_valid_q;
  logic [SumW-1:0]     tree_weight_q;
  logic [TakenW-1:0]   edges_taken_q;

  uf_ctrl_t            uf_ctrl;
  uf_rsp_t             uf_rsp;

  logic                in_acc;
  logic [31:0]         n_full;
  logic [NW-1:0]       n_cur;
  logic                ends_ok;
  logic                store_we;
  logic                rd_en;
  logic                scan_end;
  logic                stop;
  logic                out_load;
  logic [VW-1:0]       cur_u, cur_v;
  logic [WeightW-1:0]  cur_w;
  logic [KW-1:0]       cur_key;
  logic                cand;

  assign n_full = (32'(vertex_count_q) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES)
                                                           : 32'(vertex_count_q);
  assign n_cur  = n_full[NW-1:0];

  assign in_acc  = in_valid_i && !in_stall_o;
  assign ends_ok = (end_a_i != '0) && (32'(end_a_i) <= n_full) &&
                   (end_b_i != '0) && (32'(end_b_i) <= n_full);
  assign store_we = in_acc && ends_ok && (edge_total_q != ECW'(MAX_EDGES));

  assign scan_end = (scan_addr_q == edge_total_q) && !rv_q;
  assign stop     = (n_q == '0) || (taken_q == n_q - NW'(1));

  assign {cur_u, cur_v, cur_w} = rdata_q;
  assign cur_key = {~cur_w[WeightW-1], cur_w[WeightW-2:0], ridx_q};
  assign cand = rv_q && (32'(cur_u) < 32'(n_q)) && (32'(cur_v) < 32'(n_q)) &&
                (!have_prev_q || (cur_key > prev_key_q)) &&
                (!have_best_q || (cur_key < best_key_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc && last_edge_i) begin
          state_d = S_START;
        end
      end
      S_START: state_d = S_INIT;
      S_INIT: begin
        if (uf_rsp.done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: state_d = stop ? S_DONE : S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_d = have_best_q ? S_ISSUE : S_DONE;
        end
      end
      S_ISSUE: state_d = S_UNION;
      S_UNION: begin
        if (uf_rsp.done) begin
          state_d = S_CHECK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != S_LOAD);
    uf_ctrl.init = (state_q == S_START);
    uf_ctrl.go   = (state_q == S_ISSUE);
    rd_en        = (state_q == S_SCAN) && (scan_addr_q != edge_total_q);
    out_load     = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_LOAD;
      vertex_count_q <= VertexPortW'(1);
      edge_total_q   <= '0;
      n_q            <= '0;
      taken_q        <= '0;
      scan_addr_q    <= '0;
      rv_q           <= 1'b0;
      have_best_q    <= 1'b0;
      have_prev_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        vertex_count_q <= cfg_wdata_i;
      end
      if (store_we) begin
        edge_total_q <= edge_total_q + ECW'(1);
      end else if (out_load) begin
        edge_total_q <= '0;
      end
      rv_q <= rd_en;
      if (rd_en) begin
        scan_addr_q <= scan_addr_q + ECW'(1);
      end
      if (cand) begin
        have_best_q <= 1'b1;
      end
      unique case (state_q)
        S_START: begin
          n_q         <= n_cur;
          taken_q     <= '0;
          have_prev_q <= 1'b0;
        end
        S_CHECK: begin
          scan_addr_q <= '0;
          have_best_q <= 1'b0;
        end
        S_ISSUE: have_prev_q <= 1'b1;
        S_UNION: begin
          if (uf_rsp.done && uf_rsp.merged) begin
            taken_q <= taken_q + NW'(1);
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= scan_addr_q[EAW-1:0];
    if (cand) begin
      best_key_q <= cur_key;
      best_u_q   <= cur_u;
      best_v_q   <= cur_v;
      best_w_q   <= cur_w;
    end
    if (state_q == S_START) begin
      total_q <= '0;
    end else if (state_q == S_ISSUE) begin
      prev_key_q <= best_key_q;
    end else if (state_q == S_UNION && uf_rsp.done && uf_rsp.merged) begin
      total_q <= total_q + {{(SumW-WeightW){best_w_q[WeightW-1]}}, best_w_q};
    end
    if (out_load) begin
      tree_weight_q <= total_q;
      edges_taken_q <= TakenW'(32'(taken_q));
    end
  end

  // edge store: one write port at load, one registered read port for the scan
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      edge_mem[edge_total_q[EAW-1:0]] <= {VW'(32'(end_a_i) - 32'd1),
                                          VW'(32'(end_b_i) - 32'd1), weight_i};
    end
    if (rd_en) begin
      rdata_q <= edge_mem[scan_addr_q[EAW-1:0]];
    end
  end

  mstw_uf #(
    .MAX_VERTICES(MAX_VERTICES),
    .VW          (VW),
    .NW          (NW)
  ) u_uf (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(uf_ctrl),
    .n_i   (n_q),
    .a_i   (best_u_q),
    .b_i   (best_v_q),
    .rsp_o (uf_rsp)
  );

  assign out_valid_o   = out_valid_q;
  assign tree_weight_o = tree_weight_q;
  assign edges_taken_o = edges_taken_q;

`ifndef SYNTHESIS
  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edge_total_q) <= 32'(MAX_EDGES))
    else $error("edge count above capacity");

  a_taken_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q != '0) |-> (taken_q < n_q))
    else $error("more tree edges than n-1");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside done state");

  a_merge_in_union: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uf_rsp.merged |-> (state_q == S_UNION))
    else $error("merge reported outside union wait");
`endif

endmodule

// ----- tb/tb_minimum_spanning_tree_weight.sv -----
// Testbench for the minimum spanning tree weight block: directed and random graphs.
`timescale 1ns / 1ps

module tb_minimum_spanning_tree_weight;
  import mstw_pkg::*;

  localparam int MaxV     = 1024;
  localparam int MaxE     = 4096;
  localparam int CycLimit = 3000000;

  typedef struct packed {
    logic signed [SumW-1:0] tree_weight;
    logic [TakenW-1:0]      edges_taken;
  } mst_sum_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [VertexPortW-1:0]     cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [VertexPortW-1:0]     end_a_i = '0;
  logic [VertexPortW-1:0]     end_b_i = '0;
  logic signed [WeightW-1:0]  weight_i = '0;
  logic                       last_edge_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SumW-1:0]     tree_weight_o;
  logic [TakenW-1:0]          edges_taken_o;

  minimum_spanning_tree_weight #(.MAX_VERTICES(MaxV), .MAX_EDGES(MaxE)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .end_a_i, .end_b_i, .weight_i, .last_edge_i, .out_valid_o, .out_stall_i,
    .tree_weight_o, .edges_taken_o
  );

  // predictor state
  logic [VertexPortW-1:0] vcount;
  int                     graph_u [MaxE];
  int                     graph_v [MaxE];
  int                     graph_w [MaxE];
  int                     graph_len;
  int                     parent [MaxV];
  mst_sum_t               pending_sums [$];

  int errors;
  int cyc;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycLimit) begin
      $display("** minimum_spanning_tree_weight: FAILED **");
      $finish;
    end
  end

  function automatic int root_of(int x, int n);
    int steps;
    steps = 0;
    while (parent[x] != x && steps < n) begin
      x = parent[x];
      if (x >= n) break;
      steps++;
    end
    return x;
  endfunction

  // Fold one accepted edge into the graph; on the last edge push the tree sum.
  function automatic void absorb_edge(int a, int b, int w, bit last);
    int n, i, j, tu, tv, tw, taken, ra, rb;
    longint total;
    mst_sum_t res;
    n = (vcount > MaxV) ? MaxV : vcount;
    if (a >= 1 && a <= n && b >= 1 && b <= n && graph_len < MaxE) begin
      graph_u[graph_len] = a - 1;
      graph_v[graph_len] = b - 1;
      graph_w[graph_len] = w;
      graph_len++;
    end
    if (!last) return;
    // stable insertion sort by weight
    for (i = 1; i < graph_len; i++) begin
      tu = graph_u[i]; tv = graph_v[i]; tw = graph_w[i];
      j = i - 1;
      while (j >= 0 && graph_w[j] > tw) begin
        graph_u[j+1] = graph_u[j]; graph_v[j+1] = graph_v[j]; graph_w[j+1] = graph_w[j];
        j--;
      end
      graph_u[j+1] = tu; graph_v[j+1] = tv; graph_w[j+1] = tw;
    end
    for (i = 0; i < n; i++) parent[i] = i;
    taken = 0;
    total = 0;
    for (i = 0; i < graph_len; i++) begin
      if (n == 0 || taken == n - 1) break;
      if (graph_u[i] >= n || graph_v[i] >= n) continue;
      ra = root_of(graph_u[i], n);
      rb = root_of(graph_v[i], n);
      if (ra != rb) begin
        parent[rb] = ra;
        total += graph_w[i];
        taken++;
      end
    end
    graph_len = 0;
    res.tree_weight = total[31:0];
    res.edges_taken = taken[9:0];
    pending_sums.push_back(res);
  endfunction

  // receiver: random stall, long hold-off, compare each word
  always @(posedge clk_i) begin
    mst_sum_t exp_sum;
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    out_stall_i <= (hold_cycles > 1) || ($urandom_range(99) < recv_idle_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected word tree_weight=%0d edges_taken=%0d",
                 $time, tree_weight_o, edges_taken_o);
        errors++;
      end else begin
        exp_sum = pending_sums.pop_front();
        if (tree_weight_o !== exp_sum.tree_weight) begin
          $display("%0t: tree_weight expected %0d actual %0d",
                   $time, exp_sum.tree_weight, tree_weight_o);
          errors++;
        end
        if (edges_taken_o !== exp_sum.edges_taken) begin
          $display("%0t: edges_taken expected %0d actual %0d",
                   $time, exp_sum.edges_taken, edges_taken_o);
          errors++;
        end
      end
    end
  end

  task automatic send_edge(int a, int b, int w, bit last);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    end_a_i     <= a[10:0];
    end_b_i     <= b[10:0];
    weight_i    <= w[15:0];
    last_edge_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_edge(a, b, $signed(w[15:0]), last);
  endtask

  // wait for quiet, then write vertex_count
  task automatic set_vertices(int value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[10:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vcount = value[10:0];
  endtask

  task automatic test_directed();
    send_edge(1, 1, 5, 1'b1);               // single vertex, self loop
    set_vertices(5);
    send_edge(1, 2, -32768, 1'b0);
    send_edge(2, 3, 32767, 1'b0);
    send_edge(3, 3, -100, 1'b0);            // self loop
    send_edge(3, 4, 7, 1'b0);
    send_edge(1, 4, 7, 1'b0);               // equal weight
    send_edge(0, 2, -1, 1'b0);              // bad vertex
    send_edge(2, 6, -1, 1'b0);
    send_edge(2047, 1, -1, 1'b1);           // dropped final edge
    send_edge(4, 5, 32767, 1'b0);
    send_edge(5, 1, 32767, 1'b1);
    set_vertices(0);
    send_edge(1, 1, 3, 1'b0);
    send_edge(0, 0, 3, 1'b1);
    set_vertices(2047);                     // clamps to the maximum
    send_edge(1024, 1, -5, 1'b0);
    send_edge(1025, 1, -9, 1'b0);
    send_edge(1023, 1024, 11, 1'b1);
    set_vertices(8);
    send_edge(7, 8, -50, 1'b0);
    send_edge(1, 2, 10, 1'b0);
    send_edge(2, 3, 20, 1'b0);
    set_vertices(4);                        // shrink before compute
    send_edge(3, 4, 30, 1'b1);
  endtask

  task automatic random_graph(bit allow_cfg);
    int nv, ne, k, a, b;
    if (allow_cfg) begin
      case ($urandom_range(9))
        0:       nv = $urandom_range(2047, 1024);
        1:       nv = $urandom_range(1);
        default: nv = $urandom_range(16, 2);
      endcase
      set_vertices(nv);
    end
    nv = (vcount > MaxV) ? MaxV : vcount;
    ne = $urandom_range(12, 1);
    for (k = 0; k < ne; k++) begin
      if ($urandom_range(9) == 0 || nv == 0) begin
        a = $urandom_range(2047); b = $urandom_range(2047);
      end else begin
        a = $urandom_range(nv, 1); b = $urandom_range(nv, 1);
      end
      send_edge(a, b, $urandom, k == ne - 1);
    end
  endtask

  task automatic test_random(int n_items);
    int start;
    start = 0;
    while (start < n_items) begin
      random_graph($urandom_range(3) != 0);
      start += 7;
    end
  endtask

  task automatic test_pressure();
    int k;
    set_vertices(6);
    hold_cycles = 400;
    for (k = 0; k < 6; k++) random_graph(1'b0);
  endtask

  initial begin
    errors = 0;
    cyc = 0;
    hold_cycles = 0;
    graph_len = 0;
    vcount = 1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 22; recv_idle_pct = 72;
    test_random(230);
    send_idle_pct = 72; recv_idle_pct = 22;
    test_random(230);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(230);
    test_pressure();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("** minimum_spanning_tree_weight: PASSED **");
    end else begin
      $display("** minimum_spanning_tree_weight: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mstw_pkg.sv
rtl/core/mstw_uf.sv
rtl/core/minimum_spanning_tree_weight.sv
tb/tb_minimum_spanning_tree_weight.sv
